@@ design/dth_pkg.sv @@
package dth_pkg;

  localparam int unsigned DeadlineW = 64;
  localparam int unsigned TimeoutW  = 48;
  localparam int unsigned IdW       = 5;
  localparam int unsigned MaxNotices = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [DeadlineW-1:0] now_ns;
    logic [TimeoutW-1:0]  timeout_ns;
    logic                 repeat_req;
    logic [IdW-1:0]       timer_id;
  } cmd_t;

  typedef struct packed {
    logic                 kind;
    logic [IdW-1:0]       fired_id;
    logic                 status;
    logic                 armed;
    logic [DeadlineW-1:0] next_delay_ns;
    logic                 last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_SW_RD,
    ST_SW_CHK,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_DN_RD,
    ST_DN_WAIT,
    ST_DN_CMP,
    ST_FIN
  } state_e;

  function automatic logic [DeadlineW-1:0] add_sat(input logic [DeadlineW-1:0] a,
                                                   input logic [TimeoutW-1:0] b);
    logic [DeadlineW:0] s;
    s = {1'b0, a} + {{(DeadlineW-TimeoutW+1){1'b0}}, b};
    return s[DeadlineW] ? {DeadlineW{1'b1}} : s[DeadlineW-1:0];
  endfunction

endpackage

@@ design/dth_ram.sv @@
module dth_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ design/dth_front.sv @@
module dth_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dth_pkg::cmd_t cmd_i,
  output logic          q_valid_o,
  output dth_pkg::cmd_t q_cmd_o,
  input  logic          q_pop_i
);
  import dth_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  cmd_t       slot_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push;

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = !wr_q;
    end
    if (q_pop_i) begin
      rd_d = !rd_q;
    end
    case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count not advanced");

endmodule

@@ design/dth_back.sv @@
module dth_back #(
  parameter int unsigned Capacity = 32,
  parameter int unsigned IdCount  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  dth_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          res_valid_o,
  output dth_pkg::res_t res_o
);
  import dth_pkg::*;

  localparam int unsigned AW   = $clog2(Capacity + 1);
  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned EW   = DeadlineW + TimeoutW + 1 + IdW;
  localparam int unsigned NW   = $clog2(MaxNotices + 1);
  localparam int unsigned FW   = (IdCount > 1) ? $clog2(IdCount) : 1;

  typedef struct packed {
    logic [DeadlineW-1:0] dl;
    logic [TimeoutW-1:0]  per;
    logic                 rep;
    logic [IdW-1:0]       id;
  } ent_t;

  state_e            st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     pos_q, pos_d;
  ent_t              ent_q, ent_d;
  ent_t              top_q, top_d;
  logic [NW-1:0]     nn_q, nn_d;
  logic              stat_q, stat_d;
  logic              drop_q, drop_d;
  logic [IdCount-1:0] cf_q, cf_d;

  logic              we;
  logic [AW-1:0]     waddr, ra, rb;
  ent_t              wdata, rda, rdb;
  logic [EW-1:0]     rda_raw, rdb_raw;

  dth_ram #(.Width(EW), .Depth(1 << AW)) u_heap (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra),
    .rdata_a_o(rda_raw),
    .raddr_b_i(rb),
    .rdata_b_o(rdb_raw)
  );
  assign rda = ent_t'(rda_raw);
  assign rdb = ent_t'(rdb_raw);

  logic           top_cxl;
  logic [AW:0]    ch;
  logic           has_r;
  ent_t           pick;
  logic [AW-1:0]  pick_a;

  always_comb begin
    top_cxl = ({{(9-IdW){1'b0}}, top_q.id} < 9'(IdCount)) && cf_q[FW'(top_q.id)];
    ch      = {pos_q, 1'b0};
    has_r   = ((ch + 1'b1) <= (AW+1)'(cnt_q));
    if (has_r && (rdb.dl < rda.dl)) begin
      pick   = rdb;
      pick_a = AW'(ch + 1'b1);
    end else begin
      pick   = rda;
      pick_a = AW'(ch);
    end
  end

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; cnt_d = cnt_q; pos_d = pos_q;
    ent_d = ent_q; top_d = top_q; nn_d = nn_q; stat_d = stat_q; cf_d = cf_q;
    drop_d = drop_q;
    we = 1'b0; waddr = pos_q; wdata = ent_q; ra = '0; rb = '0;
    q_pop_o = 1'b0; res_valid_o = 1'b0; res_o = '0;
    case (st_q)
      ST_IDLE: begin
        ra = AW'(1);
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          nn_d    = '0;
          stat_d  = 1'b0;
          case (q_cmd_i.operation)
            OP_ADD: begin
              if (cnt_q >= CW'(Capacity)) begin
                stat_d = 1'b1;
                st_d   = ST_FIN;
              end else begin
                if ({{(9-IdW){1'b0}}, q_cmd_i.timer_id} < 9'(IdCount)) begin
                  cf_d[FW'(q_cmd_i.timer_id)] = 1'b0;
                end
                cnt_d = cnt_q + 1'b1;
                pos_d = AW'(cnt_q + 1'b1);
                ent_d = '{dl: add_sat(q_cmd_i.now_ns, q_cmd_i.timeout_ns),
                          per: q_cmd_i.timeout_ns, rep: q_cmd_i.repeat_req,
                          id: q_cmd_i.timer_id};
                st_d  = ST_UP_RD;
              end
            end
            OP_CANCEL: begin
              if ({{(9-IdW){1'b0}}, q_cmd_i.timer_id} < 9'(IdCount)) begin
                cf_d[FW'(q_cmd_i.timer_id)] = 1'b1;
              end
              st_d = ST_FIN;
            end
            OP_TICK: st_d = ST_SW_RD;
            default: st_d = ST_FIN;
          endcase
        end
      end
      ST_UP_RD: begin
        ra = pos_q >> 1;
        if (pos_q == AW'(1)) begin
          we = 1'b1; top_d = ent_q; st_d = ST_SW_CHK;
        end else begin
          st_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (ent_q.dl < rda.dl) begin
          we = 1'b1; wdata = rda; pos_d = pos_q >> 1; st_d = ST_UP_RD;
        end else begin
          we = 1'b1; st_d = (cnt_q == CW'(1)) ? ST_SW_RD : ST_FIN;
        end
      end
      ST_SW_RD: begin
        ra = AW'(1);
        st_d = ST_POP_WAIT;
        pos_d = '0;
      end
      ST_POP_WAIT: begin
        if (pos_q == '0) begin
          top_d = rda;
          st_d  = ST_SW_CHK;
        end else begin
          ra   = AW'(cnt_q);
          st_d = ST_POP_RD;
        end
      end
      ST_SW_CHK: begin
        drop_d = 1'b0;
        if (drop_q && cnt_q != '0 && top_cxl) begin
          drop_d = 1'b1; ra = AW'(cnt_q); st_d = ST_POP_RD;
        end else if (cnt_q == '0 || cmd_q.now_ns < top_q.dl) begin
          st_d = ST_FIN;
        end else if (top_cxl) begin
          drop_d = 1'b1; ra = AW'(cnt_q); st_d = ST_POP_RD;
        end else if (nn_q >= NW'(MaxNotices)) begin
          st_d = ST_FIN;
        end else begin
          res_valid_o = 1'b1;
          res_o.fired_id = top_q.id;
          nn_d = nn_q + 1'b1;
          if (top_q.rep) begin
            ent_d = top_q;
            ent_d.dl = add_sat(cmd_q.now_ns, top_q.per);
            pos_d = AW'(1);
            st_d = ST_DN_RD;
          end else begin
            ra = AW'(cnt_q); st_d = ST_POP_RD;
          end
        end
      end
      ST_POP_RD: begin
        ent_d = rda;
        cnt_d = cnt_q - 1'b1;
        pos_d = AW'(1);
        st_d  = ST_DN_RD;
      end
      ST_DN_RD: begin
        ra = AW'(ch);
        rb = AW'(ch + 1'b1);
        st_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (ch > (AW+1)'(cnt_q) || ent_q.dl < pick.dl) begin
          we = (cnt_q != '0);
          st_d = ST_SW_RD;
        end else begin
          we = 1'b1; wdata = pick; pos_d = pick_a; st_d = ST_DN_RD;
        end
      end
      ST_DN_WAIT: st_d = ST_DN_RD;
      ST_FIN: begin
        ra = AW'(1);
        st_d = ST_IDLE;
        res_valid_o = 1'b1;
        res_o.kind   = 1'b1;
        res_o.last   = 1'b1;
        res_o.status = stat_q;
        res_o.armed  = (cnt_q != '0);
        if (cnt_q != '0 && top_q.dl > cmd_q.now_ns) begin
          res_o.next_delay_ns = top_q.dl - cmd_q.now_ns;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      cf_q   <= '0;
      nn_q   <= '0;
      drop_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      cf_q   <= cf_d;
      nn_q   <= nn_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    ent_q  <= ent_d;
    stat_q <= stat_d;
    top_q  <= (st_q == ST_IDLE || st_q == ST_FIN) ? rda : top_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(Capacity))
    else $error("heap count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind) |=> st_q == ST_IDLE)
    else $error("final result not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> st_q == ST_IDLE)
    else $error("queue popped while working");

endmodule

@@ design/deadline_timer_heap_unit.sv @@
// Deadline timer heap: min-heap of timers keyed by absolute deadline.
// Order of work: a cancel goes straight to its final result; an add first rises
// level by level, each notice or drop is followed by its entry sinking level by
// level, and the final result comes last.
// Throughput: one item at a time in the back end; a two-entry queue takes
// new items meanwhile until it is full. Results are strobed and cannot be stalled.
// Reset: asynchronous, clears the heap count and all cancel marks.
module deadline_timer_heap_unit #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned ID_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] now_ns_i,
  input  logic [47:0] timeout_ns_i,
  input  logic        repeat_req_i,
  input  logic [4:0]  timer_id_i,
  output logic        strobe_o,
  output logic        kind_o,
  output logic [4:0]  fired_id_o,
  output logic        status_o,
  output logic        armed_o,
  output logic [63:0] next_delay_ns_o,
  output logic        last_o
);
  import dth_pkg::*;

  cmd_t cmd, qcmd;
  res_t res;
  logic qv, qpop, rv;

  assign cmd = '{operation: operation_i, now_ns: now_ns_i, timeout_ns: timeout_ns_i,
                 repeat_req: repeat_req_i, timer_id: timer_id_i};

  dth_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd),
    .q_valid_o(qv), .q_cmd_o(qcmd), .q_pop_i(qpop)
  );

  dth_back #(.Capacity(CAPACITY), .IdCount(ID_COUNT)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(qv), .q_cmd_i(qcmd), .q_pop_o(qpop),
    .res_valid_o(rv), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_o          <= res.kind;
    fired_id_o      <= res.fired_id;
    status_o        <= res.status;
    armed_o         <= res.armed;
    next_delay_ns_o <= res.next_delay_ns;
    last_o          <= res.last;
  end

endmodule

@@ tb/deadline_timer_heap_checker.sv @@
`timescale 1ns / 100ps

module deadline_timer_heap_checker #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned ID_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] now_ns_i,
  input  logic [47:0] timeout_ns_i,
  input  logic        repeat_req_i,
  input  logic [4:0]  timer_id_i,
  input  logic        strobe_o,
  input  logic        kind_o,
  input  logic [4:0]  fired_id_o,
  input  logic        status_o,
  input  logic        armed_o,
  input  logic [63:0] next_delay_ns_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_count
);
  import dth_pkg::*;

  logic [63:0] tq_deadline [1:CAPACITY];
  logic [47:0] tq_period [1:CAPACITY];
  logic [4:0]  tq_id [1:CAPACITY];
  logic        tq_rep [1:CAPACITY];
  int unsigned tq_count;
  logic        cancelled [ID_COUNT];
  res_t        timer_results_q [$];

  assign pending_count = timer_results_q.size();

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [47:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic swap_slots(int unsigned a, int unsigned b);
    logic [63:0] d;
    logic [47:0] p;
    logic [4:0]  i;
    logic        r;
    d = tq_deadline[a]; tq_deadline[a] = tq_deadline[b]; tq_deadline[b] = d;
    p = tq_period[a];   tq_period[a] = tq_period[b];     tq_period[b] = p;
    i = tq_id[a];       tq_id[a] = tq_id[b];             tq_id[b] = i;
    r = tq_rep[a];      tq_rep[a] = tq_rep[b];           tq_rep[b] = r;
  endtask

  task automatic sink(int unsigned pos);
    int unsigned c;
    while (2 * pos <= tq_count) begin
      c = 2 * pos;
      if (c + 1 <= tq_count && tq_deadline[c+1] < tq_deadline[c]) c++;
      if (tq_deadline[pos] < tq_deadline[c]) break;
      swap_slots(pos, c);
      pos = c;
    end
  endtask

  task automatic pop_top();
    swap_slots(1, tq_count);
    tq_count--;
    sink(1);
  endtask

  function automatic bit top_cancelled();
    return tq_id[1] < ID_COUNT && cancelled[tq_id[1]];
  endfunction

  task automatic push_result(logic k, logic [4:0] fid, logic st, logic arm,
                             logic [63:0] dly, logic lst);
    res_t r;
    r.kind = k; r.fired_id = fid; r.status = st; r.armed = arm;
    r.next_delay_ns = dly; r.last = lst;
    timer_results_q.push_back(r);
  endtask

  task automatic expire(logic [63:0] now);
    int notices;
    bit dropped;
    notices = 0;
    while (tq_count > 0 && !(now < tq_deadline[1])) begin
      dropped = 0;
      while (tq_count > 0 && top_cancelled()) begin
        pop_top();
        dropped = 1;
      end
      if (dropped) continue;
      if (notices >= MaxNotices) break;
      push_result(1'b0, tq_id[1], 1'b0, 1'b0, '0, 1'b0);
      notices++;
      if (tq_rep[1]) begin
        tq_deadline[1] = sum_sat(now, tq_period[1]);
        sink(1);
      end else begin
        pop_top();
      end
    end
  endtask

  task automatic predict_item(logic [1:0] op, logic [63:0] now, logic [47:0] tmo,
                              logic rep, logic [4:0] id);
    int unsigned pos;
    logic [63:0] dly;
    logic        st;
    st = 1'b0;
    if (op == OP_ADD) begin
      if (tq_count >= CAPACITY) begin
        st = 1'b1;
      end else begin
        if (id < ID_COUNT) cancelled[id] = 1'b0;
        tq_count++;
        tq_deadline[tq_count] = sum_sat(now, tmo);
        tq_period[tq_count] = tmo;
        tq_id[tq_count] = id;
        tq_rep[tq_count] = rep;
        pos = tq_count;
        while (pos > 1 && tq_deadline[pos] < tq_deadline[pos/2]) begin
          swap_slots(pos, pos / 2);
          pos = pos / 2;
        end
        if (tq_count == 1 || pos == 1) expire(now);
      end
    end else if (op == OP_CANCEL) begin
      if (id < ID_COUNT) cancelled[id] = 1'b1;
    end else if (op == OP_TICK) begin
      expire(now);
    end
    dly = '0;
    if (tq_count > 0 && tq_deadline[1] > now) dly = tq_deadline[1] - now;
    push_result(1'b1, '0, st, tq_count > 0, dly, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      tq_count = 0;
      for (int i = 0; i < ID_COUNT; i++) cancelled[i] = 1'b0;
      timer_results_q.delete();
      fail_count <= 0;
    end else begin
      if (strobe_o) begin
        if (timer_results_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result kind=%0d", kind_o);
        end else begin
          exp_r = timer_results_q.pop_front();
          if (exp_r.kind !== kind_o || exp_r.fired_id !== fired_id_o ||
              exp_r.status !== status_o || exp_r.armed !== armed_o ||
              exp_r.next_delay_ns !== next_delay_ns_o || exp_r.last !== last_o) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("exp k%0d id%0d st%0d a%0d d%0d l%0d got k%0d id%0d st%0d a%0d d%0d l%0d",
                exp_r.kind, exp_r.fired_id, exp_r.status, exp_r.armed,
                exp_r.next_delay_ns, exp_r.last, kind_o, fired_id_o,
                status_o, armed_o, next_delay_ns_o, last_o);
          end
        end
      end
      if (start && !busy)
        predict_item(operation_i, now_ns_i, timeout_ns_i, repeat_req_i, timer_id_i);
    end
  end

endmodule

@@ tb/deadline_timer_heap_unit_tb.sv @@
`timescale 1ns / 100ps

module deadline_timer_heap_unit_tb;
  import dth_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [63:0] now_ns_i = '0;
  logic [47:0] timeout_ns_i = '0;
  logic        repeat_req_i = 1'b0;
  logic [4:0]  timer_id_i = '0;
  logic        strobe_o, kind_o, status_o, armed_o, last_o;
  logic [4:0]  fired_id_o;
  logic [63:0] next_delay_ns_o;
  int          fail_count, pending_count;
  int          idle_pct;
  logic [63:0] clock_ns;

  always #6 clk_i = ~clk_i;

  deadline_timer_heap_unit i_dut (.*);

  deadline_timer_heap_checker i_chk (.*);

  task automatic send(logic [1:0] op, logic [63:0] now, logic [47:0] tmo,
                      logic rep, logic [4:0] id);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op; now_ns_i <= now; timeout_ns_i <= tmo;
    repeat_req_i <= rep; timer_id_i <= id;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic random_item();
    int sel;
    logic [47:0] tmo;
    logic [47:0] noise;
    logic        rep;
    logic [4:0]  id;
    sel = $urandom_range(99);
    if ($urandom_range(9) == 0) tmo = 48'({$urandom, $urandom});
    else tmo = 48'($urandom_range(3000));
    noise = 48'({$urandom, $urandom});
    rep = 1'($urandom_range(1));
    id = 5'($urandom);
    clock_ns = clock_ns + 64'($urandom_range(1500));
    if (sel < 45) send(OP_ADD, clock_ns, tmo, rep, id);
    else if (sel < 60) send(OP_CANCEL, clock_ns, noise, rep, id);
    else if (sel < 97) send(OP_TICK, clock_ns, noise, rep, id);
    else send(OP_RSVD, clock_ns, noise, rep, id);
  endtask

  initial begin
    #20_000_000;
    $display("deadline_timer_heap_unit test failed");
    $finish;
  end

  initial begin
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(OP_TICK, 64'd5, '0, 1'b0, 5'd0);
    send(OP_ADD, 64'd100, 48'd0, 1'b0, 5'd31);
    send(OP_ADD, '1, '1, 1'b1, 5'd0);
    send(OP_ADD, 64'd100, '1, 1'b0, 5'd3);
    send(OP_CANCEL, 64'd100, '0, 1'b0, 5'd3);
    send(OP_CANCEL, 64'd100, '0, 1'b0, 5'd0);
    send(OP_TICK, '1, '0, 1'b0, 5'd0);
    send(OP_RSVD, 64'd7, '1, 1'b1, 5'd31);
    for (int i = 0; i < 33; i++) send(OP_ADD, 64'd1000, 48'd50, i[0], i[4:0]);
    send(OP_TICK, 64'd2000, '0, 1'b0, 5'd0);
    send(OP_ADD, 64'd3000, 48'd0, 1'b1, 5'd9);
    for (int i = 0; i < 32; i++) send(OP_CANCEL, 64'd3000, '0, 1'b0, i[4:0]);
    send(OP_TICK, 64'd5000, '0, 1'b0, 5'd0);
    drain();
    clock_ns = 64'd10000;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 71 : (ph == 3) ? 17 : 0;
      repeat (21) random_item();
      drain();
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("deadline_timer_heap_unit test passed");
    end else begin
      $display("deadline_timer_heap_unit test failed");
    end
    $finish;
  end

endmodule
